FILE: hdl/mcoe_pkg.sv
// Shared constants, types and helper functions of the matrix column operation engine.
package mcoe_pkg;

  localparam int MAX_ROWS      = 16;
  localparam int MAX_COLS      = 16;
  localparam int ELEM_BITS     = 32;

  localparam int DEPTH         = MAX_ROWS * MAX_COLS;
  localparam int ADDR_BITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_BITS      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_BITS      = $clog2(ELEM_BITS);
  localparam int WORD_BITS     = 32;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_REG_BITS  = 5;
  localparam int RCMP_BITS     = ((ROW_BITS > CFG_REG_BITS) ? ROW_BITS : CFG_REG_BITS) + 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = CFG_IDX_BITS'(1);

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef enum logic [2:0] {
    REQ_WRITE      = 3'd0,
    REQ_READ       = 3'd1,
    REQ_COL_SCALAR = 3'd2,
    REQ_COL_COL    = 3'd3,
    REQ_SWAP       = 3'd4,
    REQ_ADD_SCALED = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_COL  = 2'd1,
    STAT_ROW  = 2'd2,
    STAT_DIV0 = 2'd3
  } status_e;

  function automatic logic [CFG_REG_BITS-1:0] clamp_cfg(input logic [CFG_REG_BITS-1:0] v,
                                                         input int hi);
    logic [CFG_REG_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_REG_BITS'(1);
    end else if (int'(v) > hi) begin
      r = CFG_REG_BITS'(hi);
    end
    return r;
  endfunction

  localparam logic [CFG_REG_BITS-1:0] ROWS_RST = clamp_cfg(CFG_REG_BITS'(16), MAX_ROWS);
  localparam logic [CFG_REG_BITS-1:0] COLS_RST = clamp_cfg(CFG_REG_BITS'(16), MAX_COLS);

  // 32-bit word to element: truncate or sign-extend
  function automatic elem_t to_elem(input logic [WORD_BITS-1:0] v);
    elem_t r;
    for (int i = 0; i < ELEM_BITS; i++) begin
      r[i] = v[(i < WORD_BITS) ? i : WORD_BITS-1];
    end
    return r;
  endfunction

  // element to 32-bit word: low bits or sign-extend
  function automatic logic [WORD_BITS-1:0] to_word(input elem_t v);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = v[(i < ELEM_BITS) ? i : ELEM_BITS-1];
    end
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [ROW_BITS-1:0] row,
                                                      input logic [COL_BITS-1:0] col);
    return ADDR_BITS'(int'(row) * MAX_COLS + int'(col));
  endfunction

endpackage

FILE: hdl/mcoe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcoe_ram #(
  parameter int  Width = 32,
  parameter int  Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/matrix_column_op_engine_unit.sv
// Top level of the matrix column operation engine: sequencer, shared ALU and matrix RAM.
//
// channel  dir  handshake                 payload
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// req      in   in_valid_i/in_ready_o     req_type_i, alu_op_i, target_col_i, source_col_i,
//                                         row_index_i, operand_value_i
// resp     out  out_valid_o/out_ready_i   read_value_o, status_o
//
// Column ops run row by row through the single RAM read port; mul, div and scaled add
// run as bit-serial steps on the shared adder, and a zero divisor leaves its row unwritten.
// Reset clears control only; the matrix RAM is undefined until written.
// A waiting response does not block a new request; the next one parks at the end.
module matrix_column_op_engine_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcoe_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [mcoe_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          req_type_i,
  input  logic [1:0]                          alu_op_i,
  input  logic [3:0]                          target_col_i,
  input  logic [3:0]                          source_col_i,
  input  logic [3:0]                          row_index_i,
  input  logic signed [31:0]                  operand_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  read_value_o,
  output logic [1:0]                          status_o
);

  localparam int EB = mcoe_pkg::ELEM_BITS;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_RDA   = 11'b000_0000_0010,
    ST_RDB   = 11'b000_0000_0100,
    ST_CAPA  = 11'b000_0000_1000,
    ST_CAPB  = 11'b000_0001_0000,
    ST_OPS   = 11'b000_0010_0000,
    ST_ITER  = 11'b000_0100_0000,
    ST_FINAL = 11'b000_1000_0000,
    ST_WRT   = 11'b001_0000_0000,
    ST_WRS   = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_e;

  state_e                                state_q, state_d;
  logic [mcoe_pkg::ROW_BITS-1:0]         r_q, r_d;
  logic [mcoe_pkg::COL_BITS-1:0]         tc_q, tc_d, sc_q, sc_d;
  mcoe_pkg::req_type_e                   type_q, type_d;
  mcoe_pkg::alu_op_e                     op_q, op_d;
  mcoe_pkg::elem_t                       val_q, val_d, a_q, a_d, b_q, b_d, res_q, res_d;
  mcoe_pkg::elem_t                       m_q, m_d, qr_q, qr_d;
  logic [EB:0]                           acc_q, acc_d;
  logic [mcoe_pkg::CNT_BITS-1:0]         cnt_q, cnt_d;
  logic                                  neg_q, neg_d, div0_q, div0_d;
  mcoe_pkg::status_e                     st_q, st_d, ost_q, ost_d;
  logic [mcoe_pkg::CFG_REG_BITS-1:0]     rows_q, rows_d, cols_q, cols_d;
  logic                                  out_valid_q, out_valid_d;
  logic [mcoe_pkg::WORD_BITS-1:0]        rdv_q, rdv_d;

  logic                                  ram_we;
  logic [mcoe_pkg::ADDR_BITS-1:0]        ram_waddr, ram_raddr;
  mcoe_pkg::elem_t                       ram_wdata, ram_rdata;

  logic [EB:0]                           alu_x, alu_y, alu_sum;
  logic                                  alu_sub;

  mcoe_pkg::elem_t                       b_op, a_mag, b_mag;
  logic                                  a_neg, b_neg, is_div, uses_src, last_row, go_next;
  logic                                  in_uses_src, col_err, row_err;
  logic [EB:0]                           rem_sh;

  mcoe_ram #(
    .Width (EB),
    .Depth (mcoe_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign b_op     = (type_q == mcoe_pkg::REQ_COL_SCALAR) ? val_q : b_q;
  assign a_neg    = a_q[EB-1];
  assign b_neg    = b_op[EB-1];
  assign a_mag    = a_neg ? (mcoe_pkg::elem_t'(0) - a_q) : a_q;
  assign b_mag    = b_neg ? (mcoe_pkg::elem_t'(0) - b_op) : b_op;
  assign is_div   = (type_q != mcoe_pkg::REQ_ADD_SCALED) && (op_q == mcoe_pkg::OP_DIV);
  assign uses_src = (type_q == mcoe_pkg::REQ_COL_COL) || (type_q == mcoe_pkg::REQ_SWAP) ||
                    (type_q == mcoe_pkg::REQ_ADD_SCALED);
  assign rem_sh   = {acc_q[EB-1:0], qr_q[EB-1]};
  assign last_row = (mcoe_pkg::RCMP_BITS'(r_q) + mcoe_pkg::RCMP_BITS'(1)) ==
                    mcoe_pkg::RCMP_BITS'(rows_q);

  assign in_uses_src = (req_type_i == mcoe_pkg::REQ_COL_COL) ||
                       (req_type_i == mcoe_pkg::REQ_SWAP) ||
                       (req_type_i == mcoe_pkg::REQ_ADD_SCALED);
  assign col_err = (req_type_i <= mcoe_pkg::REQ_ADD_SCALED) &&
                   (({1'b0, target_col_i} >= cols_q) ||
                    (in_uses_src && ({1'b0, source_col_i} >= cols_q)));
  assign row_err = (req_type_i <= mcoe_pkg::REQ_READ) && ({1'b0, row_index_i} >= rows_q);

  // shared adder: add/sub, multiply step, divide step, sign fix, scaled add
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_OPS: begin
        alu_x   = {1'b0, a_q};
        alu_y   = {1'b0, b_op};
        alu_sub = (op_q == mcoe_pkg::OP_SUB);
      end
      ST_ITER: begin
        if (is_div) begin
          alu_x   = rem_sh;
          alu_y   = {1'b0, m_q};
          alu_sub = 1'b1;
        end else begin
          alu_x = {1'b0, acc_q[EB-1:0]};
          alu_y = qr_q[0] ? {1'b0, m_q} : '0;
        end
      end
      ST_FINAL: begin
        if (type_q == mcoe_pkg::REQ_ADD_SCALED) begin
          alu_x = {1'b0, a_q};
          alu_y = {1'b0, acc_q[EB-1:0]};
        end else begin
          alu_y   = {1'b0, qr_q};
          alu_sub = neg_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{EB{1'b0}}, alu_sub};

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    tc_d        = tc_q;
    sc_d        = sc_q;
    type_d      = type_q;
    op_d        = op_q;
    val_d       = val_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    m_d         = m_q;
    qr_d        = qr_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    div0_d      = div0_q;
    st_d        = st_q;
    ost_d       = ost_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    rdv_d       = rdv_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = mcoe_pkg::elem_addr(r_q, tc_q);
    ram_wdata   = res_q;
    ram_raddr   = mcoe_pkg::elem_addr(r_q, tc_q);
    go_next     = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcoe_pkg::CFG_ROWS: rows_d = mcoe_pkg::clamp_cfg(
                                cfg_data_i[mcoe_pkg::CFG_REG_BITS-1:0], mcoe_pkg::MAX_ROWS);
        mcoe_pkg::CFG_COLS: cols_d = mcoe_pkg::clamp_cfg(
                                cfg_data_i[mcoe_pkg::CFG_REG_BITS-1:0], mcoe_pkg::MAX_COLS);
        default: begin
        end
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          type_d = mcoe_pkg::req_type_e'(req_type_i);
          op_d   = mcoe_pkg::alu_op_e'(alu_op_i);
          tc_d   = mcoe_pkg::COL_BITS'(target_col_i);
          sc_d   = mcoe_pkg::COL_BITS'(source_col_i);
          val_d  = mcoe_pkg::to_elem(operand_value_i);
          res_d  = mcoe_pkg::to_elem(operand_value_i);
          div0_d = 1'b0;
          st_d   = mcoe_pkg::STAT_OK;
          r_d    = '0;
          if (col_err) begin
            st_d    = mcoe_pkg::STAT_COL;
            state_d = ST_FIN;
          end else if (row_err) begin
            st_d    = mcoe_pkg::STAT_ROW;
            state_d = ST_FIN;
          end else begin
            case (req_type_i) inside
              mcoe_pkg::REQ_WRITE: begin
                r_d     = mcoe_pkg::ROW_BITS'(row_index_i);
                state_d = ST_WRT;
              end
              mcoe_pkg::REQ_READ: begin
                r_d     = mcoe_pkg::ROW_BITS'(row_index_i);
                state_d = ST_RDA;
              end
              mcoe_pkg::REQ_COL_SCALAR, mcoe_pkg::REQ_COL_COL, mcoe_pkg::REQ_SWAP,
              mcoe_pkg::REQ_ADD_SCALED: state_d = ST_RDA;
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_RDA: begin
        state_d = uses_src ? ST_RDB : ST_CAPA;
      end
      ST_RDB: begin
        ram_raddr = mcoe_pkg::elem_addr(r_q, sc_q);
        a_d       = ram_rdata;
        state_d   = ST_CAPB;
      end
      ST_CAPA: begin
        a_d     = ram_rdata;
        state_d = (type_q == mcoe_pkg::REQ_READ) ? ST_FIN : ST_OPS;
      end
      ST_CAPB: begin
        b_d     = ram_rdata;
        state_d = (type_q == mcoe_pkg::REQ_SWAP) ? ST_WRT : ST_OPS;
      end
      ST_OPS: begin
        cnt_d = mcoe_pkg::CNT_BITS'(EB - 1);
        acc_d = '0;
        if (type_q == mcoe_pkg::REQ_ADD_SCALED) begin
          m_d     = val_q;
          qr_d    = b_q;
          state_d = ST_ITER;
        end else begin
          case (op_q)
            mcoe_pkg::OP_MUL: begin
              m_d     = a_q;
              qr_d    = b_op;
              state_d = ST_ITER;
            end
            mcoe_pkg::OP_DIV: begin
              if (b_op == '0) begin
                div0_d  = 1'b1;
                go_next = 1'b1;
              end else begin
                m_d     = b_mag;
                qr_d    = a_mag;
                neg_d   = a_neg ^ b_neg;
                state_d = ST_ITER;
              end
            end
            default: begin
              res_d   = alu_sum[EB-1:0];
              state_d = ST_WRT;
            end
          endcase
        end
      end
      ST_ITER: begin
        if (is_div) begin
          if (!alu_sum[EB]) begin
            acc_d = alu_sum;
            qr_d  = {qr_q[EB-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            qr_d  = {qr_q[EB-2:0], 1'b0};
          end
        end else begin
          acc_d = {1'b0, alu_sum[EB-1:0]};
          m_d   = {m_q[EB-2:0], 1'b0};
          qr_d  = {1'b0, qr_q[EB-1:1]};
        end
        if (cnt_q == '0) begin
          state_d = ST_FINAL;
        end else begin
          cnt_d = cnt_q - mcoe_pkg::CNT_BITS'(1);
        end
      end
      ST_FINAL: begin
        if (type_q != mcoe_pkg::REQ_ADD_SCALED && op_q == mcoe_pkg::OP_MUL) begin
          res_d = acc_q[EB-1:0];
        end else begin
          res_d = alu_sum[EB-1:0];
        end
        state_d = ST_WRT;
      end
      ST_WRT: begin
        ram_we    = 1'b1;
        ram_wdata = (type_q == mcoe_pkg::REQ_SWAP) ? b_q : res_q;
        if (type_q == mcoe_pkg::REQ_WRITE) begin
          state_d = ST_FIN;
        end else if (type_q == mcoe_pkg::REQ_SWAP) begin
          state_d = ST_WRS;
        end else begin
          go_next = 1'b1;
        end
      end
      ST_WRS: begin
        ram_we    = 1'b1;
        ram_waddr = mcoe_pkg::elem_addr(r_q, sc_q);
        ram_wdata = a_q;
        go_next   = 1'b1;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ost_d       = div0_q ? mcoe_pkg::STAT_DIV0 : st_q;
          rdv_d       = (type_q == mcoe_pkg::REQ_READ && st_q == mcoe_pkg::STAT_OK) ?
                        mcoe_pkg::to_word(a_q) : '0;
          r_d         = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (go_next) begin
      if (last_row) begin
        state_d = ST_FIN;
      end else begin
        r_d     = r_q + mcoe_pkg::ROW_BITS'(1);
        state_d = ST_RDA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      cnt_q       <= '0;
      div0_q      <= 1'b0;
      st_q        <= mcoe_pkg::STAT_OK;
      rows_q      <= mcoe_pkg::ROWS_RST;
      cols_q      <= mcoe_pkg::COLS_RST;
      out_valid_q <= 1'b0;
      type_q      <= mcoe_pkg::REQ_WRITE;
      op_q        <= mcoe_pkg::OP_ADD;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      cnt_q       <= cnt_d;
      div0_q      <= div0_d;
      st_q        <= st_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      out_valid_q <= out_valid_d;
      type_q      <= type_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tc_q  <= tc_d;
    sc_q  <= sc_d;
    val_q <= val_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    m_q   <= m_d;
    qr_q  <= qr_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    ost_q <= ost_d;
    rdv_q <= rdv_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rdv_q;
  assign status_o     = ost_q;

`ifndef NO_ASSERTIONS
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |->
      (mcoe_pkg::RCMP_BITS'(r_q) < mcoe_pkg::RCMP_BITS'(rows_q)))
    else $error("row counter beyond rows in use");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && is_div) |-> (acc_q < {1'b0, m_q}))
    else $error("divide remainder not below divisor");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while still idle next cycle");

  a_read_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_value_o != '0) |-> (status_o == mcoe_pkg::STAT_OK))
    else $error("nonzero read value with error status");
`endif

endmodule
